### rtl/core/lbpe_pkg.sv
package lbpe_pkg;

	localparam int TAB_DIM   = 7;
	localparam int SENSOR_W  = 7;
	localparam int ENTRY_W   = 11;
	localparam int SUM_W     = 17;
	localparam int CNT_W     = 6;
	localparam int POS_W     = 11;
	localparam int LED_OUT_W = 3;
	localparam int COL_W     = 3;
	localparam int POS_LIMIT = 1000;

	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic signed [POS_W-1:0]   pos_t;
	typedef logic [COL_W-1:0]          col_t;

	typedef struct packed {
		entry_t entry;
		logic   hit;
	} lane_res_t;

	typedef struct packed {
		logic done;
		pos_t quot;
	} div_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_EMIT
	} state_t;

	// [sensor][led], thousandths of full scale
	localparam entry_t POS_TABLE [TAB_DIM][TAB_DIM] = '{
		'{ 11'sd1000,  11'sd900,   11'sd800,   11'sd0,     11'sd0,     11'sd0,     11'sd0    },
		'{ 11'sd0,     11'sd0,     11'sd0,     11'sd700,   11'sd600,   11'sd500,   11'sd0    },
		'{ 11'sd300,   11'sd200,   11'sd0,     11'sd0,     11'sd0,     11'sd0,     11'sd400  },
		'{ 11'sd0,     11'sd0,     11'sd100,   11'sd1,    -11'sd100,   11'sd0,     11'sd0    },
		'{-11'sd400,   11'sd0,     11'sd0,     11'sd0,     11'sd0,    -11'sd200,  -11'sd300  },
		'{ 11'sd0,    -11'sd500,  -11'sd600,  -11'sd700,   11'sd0,     11'sd0,     11'sd0    },
		'{ 11'sd0,     11'sd0,     11'sd0,     11'sd0,    -11'sd800,  -11'sd900,  -11'sd1000 }
	};

endpackage

### rtl/core/lbpe_lane.sv
module lbpe_lane
	import lbpe_pkg::*;
#(
	parameter int ROW = 0
) (
	input  logic      clk,
	input  logic      load,
	input  logic      active,
	input  col_t      col,
	input  logic      col_ok,
	output lane_res_t res_s1
);

	entry_t entry;

	always_comb begin
		entry = '0;
		if (active && col_ok) begin
			entry = POS_TABLE[ROW][col];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s1.entry <= entry;
			res_s1.hit   <= (entry != '0);
		end
	end

endmodule

### rtl/core/lbpe_merge.sv
module lbpe_merge
	import lbpe_pkg::*;
#(
	parameter int NUM_LANES = 7
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      acc_en,
	input  logic      clear,
	input  lane_res_t lanes [NUM_LANES],
	output sum_t      sum_next,
	output cnt_t      cnt_next
);

	sum_t sum_q;
	cnt_t cnt_q;

	always_comb begin
		sum_next = sum_q;
		cnt_next = cnt_q;
		for (int i = 0; i < NUM_LANES; i++) begin
			sum_next = sum_next + sum_t'(lanes[i].entry);
			cnt_next = cnt_next + cnt_t'(lanes[i].hit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (acc_en) begin
			if (clear) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_next;
			end
		end
	end

endmodule

### rtl/core/lbpe_div.sv
module lbpe_div
	import lbpe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  sum_t     num,
	input  cnt_t     den,
	output div_res_t res
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  mag_q;
	logic [CNT_W:0]    rem_q;
	cnt_t              den_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [SUM_W-1:0]  num_mag;
	logic [CNT_W:0]    rem_sh;
	logic              qbit;
	logic [POS_W-1:0]  quot_sat;

	assign num_mag = num[SUM_W-1] ? (~num + 1'b1) : num;
	assign rem_sh  = {rem_q[CNT_W-1:0], mag_q[SUM_W-1]};
	assign qbit    = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num_mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[SUM_W-1];
		end else if (busy_q) begin
			mag_q <= {mag_q[SUM_W-2:0], qbit};
			rem_q <= qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
		end
	end

	always_comb begin
		if (den_q == '0) begin
			quot_sat = '0;
		end else if (mag_q > SUM_W'(POS_LIMIT)) begin
			quot_sat = POS_W'(POS_LIMIT);
		end else begin
			quot_sat = mag_q[POS_W-1:0];
		end
		res.done = done_q;
		res.quot = neg_q ? pos_t'(-quot_sat) : pos_t'(quot_sat);
	end

endmodule

### rtl/core/light_barrier_position_estimator.sv
// Scans NUM_CHANNELS LEDs against the sensor row. Each item carries the sensor
// bits seen while the LED on led_select is lit (bit clear means the sensor is
// active) and gives one result item: the LED for the next step, the latest
// position in thousandths and frame_done on the step that closes a scan. One
// item is in work at a time. A step runs through the lane registers, SUM and
// EMIT into the output register; the closing step also waits in DIV for the
// 17-bit serial divider that forms sum / count one quotient bit a cycle. A new
// item is accepted once a result is in the output register, even if not taken.
module light_barrier_position_estimator
	import lbpe_pkg::*;
#(
	parameter int NUM_CHANNELS = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [SENSOR_W-1:0]  sensor_bits,
	input  logic                 sensor_valid,
	output logic                 sensor_stall,
	output logic [LED_OUT_W-1:0] led_select,
	output pos_t                 position_milli,
	output logic                 frame_done,
	output logic                 result_valid,
	input  logic                 result_stall
);

	localparam int LED_W     = (NUM_CHANNELS > 2) ? $clog2(NUM_CHANNELS) : 1;
	localparam int NUM_LANES = (NUM_CHANNELS < TAB_DIM) ? NUM_CHANNELS : TAB_DIM;
	localparam int EXT_W     = LED_W + LED_OUT_W;

	state_t state_q, state_d;

	logic [LED_W-1:0] led_q;
	logic [EXT_W-1:0] led_ext;
	logic             last_led;
	logic             frame_q;
	pos_t             position_q;

	logic             lane_load;
	logic             acc_en;
	logic             div_start;
	logic             emit;

	lane_res_t        lanes [NUM_LANES];
	sum_t             sum_next;
	cnt_t             cnt_next;
	div_res_t         div_res;

	logic [LED_OUT_W-1:0] led_out_q;
	pos_t                 pos_out_q;
	logic                 done_out_q;
	logic                 valid_out_q;

	assign led_ext  = {{LED_OUT_W{1'b0}}, led_q};
	assign last_led = (led_q == LED_W'(NUM_CHANNELS - 1));

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		lbpe_lane #(
			.ROW(i)
		) u_lane (
			.clk    (clk),
			.load   (lane_load),
			.active (~sensor_bits[i]),
			.col    (led_ext[COL_W-1:0]),
			.col_ok (led_ext < EXT_W'(TAB_DIM)),
			.res_s1 (lanes[i])
		);
	end

	lbpe_merge #(
		.NUM_LANES(NUM_LANES)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc_en   (acc_en),
		.clear    (last_led),
		.lanes    (lanes),
		.sum_next (sum_next),
		.cnt_next (cnt_next)
	);

	lbpe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_next),
		.den    (cnt_next),
		.res    (div_res)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sensor_valid) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				state_d = last_led ? ST_DIV : ST_EMIT;
			end
			ST_DIV: begin
				if (div_res.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!valid_out_q || !result_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		sensor_stall = (state_q != ST_IDLE);
		lane_load    = (state_q == ST_IDLE);
		acc_en       = (state_q == ST_SUM);
		div_start    = (state_q == ST_SUM) && last_led;
		emit         = (state_q == ST_EMIT) && (!valid_out_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			led_q       <= '0;
			frame_q     <= 1'b0;
			position_q  <= '0;
			valid_out_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc_en) begin
				led_q   <= last_led ? '0 : led_q + 1'b1;
				frame_q <= last_led;
			end
			if (div_res.done) begin
				position_q <= div_res.quot;
			end
			if (emit) begin
				valid_out_q <= 1'b1;
			end else if (!result_stall) begin
				valid_out_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			led_out_q  <= led_ext[LED_OUT_W-1:0];
			pos_out_q  <= position_q;
			done_out_q <= frame_q;
		end
	end

	assign led_select     = led_out_q;
	assign position_milli = pos_out_q;
	assign frame_done     = done_out_q;
	assign result_valid   = valid_out_q;

endmodule

### tb/testbench.sv
module testbench;
	import lbpe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int N_RANDOM = 1700;
	localparam int N_LEDS = 7;
	localparam int POS_MAX = 1000;

	// [sensor][led] in thousandths
	localparam int BEAM_MAP [N_LEDS][N_LEDS] = '{
		'{ 1000,  900,  800,    0,    0,    0,     0},
		'{    0,    0,    0,  700,  600,  500,     0},
		'{  300,  200,    0,    0,    0,    0,   400},
		'{    0,    0,  100,    1, -100,    0,     0},
		'{ -400,    0,    0,    0,    0, -200,  -300},
		'{    0, -500, -600, -700,    0,    0,     0},
		'{    0,    0,    0,    0, -800, -900, -1000}
	};

	typedef struct {
		logic [LED_OUT_W-1:0] led;
		pos_t                 pos;
		logic                 done;
	} step_result_t;

	class frame_tracker;
		step_result_t pending_steps[$];
		int unsigned  led_idx;
		int           beam_sum;
		int unsigned  beam_hits;
		int           last_pos;
		bit           failed;

		function void note_scan(logic [SENSOR_W-1:0] bits);
			step_result_t r;
			int quot;
			for (int s = 0; s < N_LEDS; s++) begin
				if (!bits[s]) begin
					beam_sum += BEAM_MAP[s][led_idx];
					if (BEAM_MAP[s][led_idx] != 0)
						beam_hits++;
				end
			end
			led_idx++;
			r.done = 1'b0;
			if (led_idx >= N_LEDS) begin
				quot = (beam_hits == 0) ? 0 : beam_sum / int'(beam_hits);
				if (quot > POS_MAX)
					quot = POS_MAX;
				if (quot < -POS_MAX)
					quot = -POS_MAX;
				last_pos = quot;
				led_idx = 0;
				beam_sum = 0;
				beam_hits = 0;
				r.done = 1'b1;
			end
			r.led = LED_OUT_W'(led_idx);
			r.pos = pos_t'(last_pos);
			pending_steps.push_back(r);
		endfunction

		function void check_step(logic [LED_OUT_W-1:0] led, pos_t pos, logic done);
			step_result_t r;
			if (pending_steps.size() == 0) begin
				$error("result item with nothing pending: led_select %0d position_milli %0d",
					led, pos);
				failed = 1'b1;
				return;
			end
			r = pending_steps.pop_front();
			if (led !== r.led) begin
				$error("led_select: expected %0d, got %0d", r.led, led);
				failed = 1'b1;
			end
			if (pos !== r.pos) begin
				$error("position_milli: expected %0d, got %0d", r.pos, pos);
				failed = 1'b1;
			end
			if (done !== r.done) begin
				$error("frame_done: expected %0d, got %0d", r.done, done);
				failed = 1'b1;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic [SENSOR_W-1:0]  sensor_bits = '1;
	logic                 sensor_valid = 1'b0;
	logic                 sensor_stall;
	logic [LED_OUT_W-1:0] led_select;
	pos_t                 position_milli;
	logic                 frame_done;
	logic                 result_valid;
	logic                 result_stall = 1'b0;

	frame_tracker tracker = new;
	bit           calm = 1'b0;
	int unsigned  cycle_count = 0;

	light_barrier_position_estimator #(
		.NUM_CHANNELS(N_LEDS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sensor_bits   (sensor_bits),
		.sensor_valid  (sensor_valid),
		.sensor_stall  (sensor_stall),
		.led_select    (led_select),
		.position_milli(position_milli),
		.frame_done    (frame_done),
		.result_valid  (result_valid),
		.result_stall  (result_stall)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [SENSOR_W-1:0] pick_bits();
		case ($urandom_range(0, 3))
			0: return SENSOR_W'($urandom);
			1: return SENSOR_W'($urandom | $urandom);
			2: return SENSOR_W'($urandom & $urandom);
			default: return ~(SENSOR_W'(1) << $urandom_range(0, SENSOR_W - 1));
		endcase
	endfunction

	task automatic send_scan(logic [SENSOR_W-1:0] bits);
		int gap;
		sensor_bits <= bits;
		sensor_valid <= 1'b1;
		do @(posedge clk); while (sensor_stall);
		tracker.note_scan(bits);
		gap = (calm || $urandom_range(0, 1)) ? 0 : idle_len();
		if (gap > 0) begin
			sensor_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(logic [SENSOR_W-1:0] bits [N_LEDS]);
		for (int l = 0; l < N_LEDS; l++)
			send_scan(bits[l]);
	endtask

	// result side: checks taken items, random stalls
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (result_valid === 1'b1 && !result_stall)
				tracker.check_step(led_select, position_milli, frame_done);
			if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
				stall_left = idle_len();
			result_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [SENSOR_W-1:0] frame [N_LEDS];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty frame
		frame = '{default: '1};
		send_frame(frame);
		// only the center entry
		frame[3] = ~(SENSOR_W'(1) << 3);
		send_frame(frame);
		// every sensor active on every led
		frame = '{default: '0};
		send_frame(frame);
		// single hit at the positive end
		frame = '{default: '1};
		frame[0] = ~SENSOR_W'(1);
		send_frame(frame);

		for (int n = 0; n < N_RANDOM; n++) begin
			calm = ((n / 150) % 5 == 2);
			send_scan(pick_bits());
		end
		calm = 1'b0;
		sensor_valid <= 1'b0;

		while (tracker.pending_steps.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (!tracker.failed && tracker.pending_steps.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/lbpe_pkg.sv
rtl/core/lbpe_lane.sv
rtl/core/lbpe_merge.sv
rtl/core/lbpe_div.sv
rtl/core/light_barrier_position_estimator.sv
tb/testbench.sv
